### src/mpu_region_table_encoder_assert.svh
// Assertion macros for the MPU region table encoder.
// Included by the top level; expects clk and arst_n in the including scope.
`ifndef MPU_REGION_TABLE_ENCODER_ASSERT_SVH
`define MPU_REGION_TABLE_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property outside reset
`define MPURTE_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("mpu_region_table_encoder: assertion failed");
// Check a property that must also hold while reset is applied
`define MPURTE_ASSERT_IN_RESET(label, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("mpu_region_table_encoder: reset assertion failed");
`else
`define MPURTE_ASSERT(label, prop)
`define MPURTE_ASSERT_IN_RESET(label, prop)
`endif

`endif

### src/mpurte_pkg.sv
// Shared types and constants for the MPU region table encoder.
// No dependencies; used by mpurte_cmd_unit and mpu_region_table_encoder.
package mpurte_pkg;

	// Default number of MPU regions
	localparam int unsigned REGIONS_DEF = 8;

	// Field widths
	localparam int unsigned ID_W   = 4;
	localparam int unsigned ADDR_W = 32;
	localparam int unsigned SIZE_W = 33;
	localparam int unsigned RN_W   = 3;

	// Stream and APB widths
	localparam int unsigned S_TDATA_W  = 80;
	localparam int unsigned S_TUSER_W  = 2;
	localparam int unsigned M_TDATA_W  = 72;
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;

	// Register word index
	localparam logic REG_MPU_PRESENT = 1'b0;

	// RBAR keeps the address bits above the 32-byte granule
	localparam logic [ADDR_W-1:0] RBAR_MASK = 32'hFFFF_FFE0;

	// Memory type codes of a command
	localparam logic [2:0] MT_ROM   = 3'd0;
	localparam logic [2:0] MT_RAM   = 3'd1;
	localparam logic [2:0] MT_PSRAM = 3'd2;
	localparam logic [2:0] MT_NOR   = 3'd3;
	localparam logic [2:0] MT_OTHER = 3'd4;

	// Access permission codes of a command
	localparam logic [1:0] PERM_RW_PRIV = 2'd0;
	localparam logic [1:0] PERM_RW_ANY  = 2'd1;
	localparam logic [1:0] PERM_RO_PRIV = 2'd2;
	localparam logic [1:0] PERM_RO_ANY  = 2'd3;

	// RASR.AP encodings
	localparam logic [2:0] AP_RW_PRIV = 3'd1;
	localparam logic [2:0] AP_RW_ANY  = 3'd3;
	localparam logic [2:0] AP_RO_PRIV = 3'd5;
	localparam logic [2:0] AP_RO_ANY  = 3'd6;

	typedef enum logic [1:0] {
		OP_SET     = 2'd0,
		OP_DISABLE = 2'd1,
		OP_FIND    = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		WS_NONE = 2'd0,
		WS_FULL = 2'd1,
		WS_RASR = 2'd2
	} wstrobe_t;

	// Command payload of one input beat
	typedef struct packed {
		logic [ID_W-1:0]   region_id;
		logic [ADDR_W-1:0] base_address;
		logic [SIZE_W-1:0] region_size;
		logic [1:0]        access_permission;
		logic [2:0]        memory_type;
		logic              execute_never;
		logic              shareable;
	} cmd_t;

	// One result beat
	typedef struct packed {
		logic              status;
		wstrobe_t          write_strobe;
		logic [RN_W-1:0]   region_number;
		logic [ADDR_W-1:0] rbar_value;
		logic [ADDR_W-1:0] rasr_value;
	} result_t;

endpackage

### src/mpurte_cmd_unit.sv
// Command evaluation for the MPU region table encoder: checks, RBAR/RASR
// packing and region flag update. Depends on mpurte_pkg.
module mpurte_cmd_unit #(
	parameter int unsigned REGIONS = mpurte_pkg::REGIONS_DEF
) (
	input  mpurte_pkg::opcode_t opcode,
	input  mpurte_pkg::cmd_t    cmd,
	input  logic [REGIONS-1:0]  region_used,
	input  logic                mpu_present,
	output mpurte_pkg::result_t result,
	output logic [REGIONS-1:0]  region_used_nxt,
	output logic [REGIONS-1:0]  id_sel
);
	import mpurte_pkg::*;

	localparam logic [ID_W:0] REGIONS_L = (ID_W+1)'(REGIONS);

	// Map access permission to the RASR.AP code
	function automatic logic [2:0] ap_code(input logic [1:0] perm);
		logic [2:0] ap;
		case (perm)
			PERM_RW_PRIV: ap = AP_RW_PRIV;
			PERM_RW_ANY:  ap = AP_RW_ANY;
			PERM_RO_PRIV: ap = AP_RO_PRIV;
			default:      ap = AP_RO_ANY;
		endcase
		return ap;
	endfunction

	logic            id_ok;
	logic            used_hit;
	logic            size_ok;
	logic [4:0]      size_code;
	logic            misaligned;
	logic            any_free;
	logic [RN_W-1:0] free_idx;
	logic            mt_c;
	logic            mt_b;
	logic [ADDR_W-1:0] rasr;

	// Decode the region id to a one-hot select
	always_comb begin
		for (int i = 0; i < REGIONS; i++) begin
			id_sel[i] = (cmd.region_id == ID_W'(i));
		end
	end

	assign id_ok    = ({1'b0, cmd.region_id} < REGIONS_L);
	assign used_hit = |(region_used & id_sel);

	// Size must be a single set bit at position 5..32
	assign size_ok = (cmd.region_size != '0)
		&& ((cmd.region_size & (cmd.region_size - SIZE_W'(1))) == '0)
		&& (cmd.region_size[4:0] == 5'd0);

	// Encode the set bit as log2 minus one
	always_comb begin
		size_code = 5'd0;
		for (int k = 5; k < SIZE_W; k++) begin
			if (cmd.region_size[k]) begin
				size_code = size_code | 5'(k - 1);
			end
		end
	end

	assign misaligned = |({1'b0, cmd.base_address} & (cmd.region_size - SIZE_W'(1)));

	// Find the lowest free region; scan downward so the lowest wins
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = REGIONS - 1; i >= 0; i--) begin
			if (!region_used[i]) begin
				any_free = 1'b1;
				free_idx = RN_W'(i);
			end
		end
	end

	// Cacheable and bufferable bits from the memory type
	always_comb begin
		case (cmd.memory_type) inside
			MT_ROM, MT_RAM: begin
				mt_c = 1'b1;
				mt_b = 1'b0;
			end
			MT_PSRAM: begin
				mt_c = 1'b1;
				mt_b = 1'b1;
			end
			MT_NOR: begin
				mt_c = 1'b0;
				mt_b = 1'b1;
			end
			default: begin
				mt_c = 1'b0;
				mt_b = 1'b0;
			end
		endcase
	end

	// Pack RASR: enable, size, B, C, S, AP, XN
	always_comb begin
		rasr        = '0;
		rasr[0]     = 1'b1;
		rasr[5:1]   = size_code;
		rasr[16]    = mt_b;
		rasr[17]    = mt_c;
		rasr[18]    = cmd.shareable;
		rasr[26:24] = ap_code(cmd.access_permission);
		rasr[28]    = cmd.execute_never;
	end

	// Evaluate the command; default is the error result with flags held
	always_comb begin
		result          = '0;
		result.status   = 1'b1;
		result.write_strobe = WS_NONE;
		region_used_nxt = region_used;
		unique case (opcode)
			OP_SET: begin
				if (id_ok && mpu_present && size_ok && !misaligned && !used_hit) begin
					result.status        = 1'b0;
					result.write_strobe  = WS_FULL;
					result.region_number = cmd.region_id[RN_W-1:0];
					result.rbar_value    = cmd.base_address & RBAR_MASK;
					result.rasr_value    = rasr;
					region_used_nxt      = region_used | id_sel;
				end
			end
			OP_DISABLE: begin
				if (id_ok && used_hit) begin
					result.status        = 1'b0;
					result.write_strobe  = mpu_present ? WS_RASR : WS_NONE;
					result.region_number = cmd.region_id[RN_W-1:0];
					region_used_nxt      = region_used & ~id_sel;
				end
			end
			OP_FIND: begin
				if (any_free) begin
					result.status        = 1'b0;
					result.region_number = free_idx;
				end
			end
			default: begin
				result.status = 1'b1;
			end
		endcase
	end

endmodule

### src/mpu_region_table_encoder.sv
// Top level of the MPU region table encoder: stream ports, APB register,
// input and result registers. Depends on mpurte_pkg and mpurte_cmd_unit.
//
//   channel   | direction | beat
//   s_*       | in        | one command (opcode in tuser, fields in tdata)
//   m_*       | out       | one result per command
//   APB       | in/out    | mpu_present register at byte address 0
//
// One command per cycle while the result stream is not stalled: a beat
// lands in the input register, then the command unit evaluates it against
// the region flags and the result register loads its result.
// Reset clears the region flags, both valid bits and sets mpu_present.
// A stalled result holds the result register; the input register keeps
// accepting as long as it can drain into the result register.
`include "mpu_region_table_encoder_assert.svh"

module mpu_region_table_encoder #(
	parameter int unsigned REGIONS = mpurte_pkg::REGIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// APB configuration
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [mpurte_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [mpurte_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [mpurte_pkg::APB_DATA_W-1:0]  prdata,
	output logic                               pready,
	// Command stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [3:0] region_id, [35:4] base_address, [68:36] region_size,
	// [70:69] access_permission, [73:71] memory_type, [74] execute_never,
	// [75] shareable, [79:76] zero
	input  logic [mpurte_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] opcode
	input  logic [mpurte_pkg::S_TUSER_W-1:0]   s_tuser,
	// Result stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] status, [2:1] write_strobe, [5:3] region_number,
	// [37:6] rbar_value, [69:38] rasr_value, [71:70] zero
	output logic [mpurte_pkg::M_TDATA_W-1:0]   m_tdata
);
	import mpurte_pkg::*;

	logic               mpu_present_q;
	logic [REGIONS-1:0] region_used_q;
	logic [REGIONS-1:0] region_used_nxt;
	logic [REGIONS-1:0] id_sel;

	logic               valid_s1;
	opcode_t            opcode_s1;
	cmd_t               cmd_s1;

	logic               out_valid_q;
	result_t            result_q;
	result_t            result;

	logic               advance;
	logic               in_beat;
	logic               cfg_wr;
	logic               set_done;

	// APB: always ready, one register on word index 0
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_MPU_PRESENT);
	assign prdata = ((paddr[2] == REG_MPU_PRESENT) && (paddr[1:0] == 2'd0))
		? {{(APB_DATA_W-1){1'b0}}, mpu_present_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpu_present_q <= 1'b1;
		end else if (cfg_wr) begin
			mpu_present_q <= pwdata[0];
		end
	end

	// Handshake: result register drains or is empty, input follows it
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign in_beat  = s_tvalid && s_tready;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_beat) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			opcode_s1                <= opcode_t'(s_tuser[1:0]);
			cmd_s1.region_id         <= s_tdata[3:0];
			cmd_s1.base_address      <= s_tdata[35:4];
			cmd_s1.region_size       <= s_tdata[68:36];
			cmd_s1.access_permission <= s_tdata[70:69];
			cmd_s1.memory_type       <= s_tdata[73:71];
			cmd_s1.execute_never     <= s_tdata[74];
			cmd_s1.shareable         <= s_tdata[75];
		end
	end

	mpurte_cmd_unit #(
		.REGIONS(REGIONS)
	) u_cmd (
		.opcode         (opcode_s1),
		.cmd            (cmd_s1),
		.region_used    (region_used_q),
		.mpu_present    (mpu_present_q),
		.result         (result),
		.region_used_nxt(region_used_nxt),
		.id_sel         (id_sel)
	);

	// Result valid and region flags advance together
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			region_used_q <= '0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				region_used_q <= region_used_nxt;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, result_q.rasr_value, result_q.rbar_value,
		result_q.region_number, result_q.write_strobe, result_q.status};

	// A set that succeeds as it leaves the input register
	assign set_done = advance && valid_s1 && (opcode_s1 == OP_SET) && !result.status;

	// A successful set leaves its region marked used
	`MPURTE_ASSERT(a_set_marks_used, set_done |=> (|(region_used_q & $past(id_sel))))
	// A rejected command never asks for a register write
	`MPURTE_ASSERT(a_err_no_write, (out_valid_q && result_q.status) |-> (result_q.write_strobe == WS_NONE))
	// No result is offered while reset is applied
	`MPURTE_ASSERT_IN_RESET(a_reset_idle, (!arst_n) |-> (!m_tvalid && !valid_s1))

endmodule

### dv/tb.sv
// Self-checking testbench for mpu_region_table_encoder: command stream in,
// result stream out. Uses mpurte_pkg; the APB register is set between phases.
// Results are checked against a region-table model.
`timescale 1ns / 100ps

module tb;
	import mpurte_pkg::*;

	localparam int unsigned REGIONS = REGIONS_DEF;
	localparam int unsigned PRESSURE_CYCLES = 80;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;
	localparam logic [APB_ADDR_W-1:0] MPU_PRESENT_ADDR = {REG_MPU_PRESENT, 2'b00};

	localparam result_t ERR_RESULT = '{1'b1, WS_NONE, 3'd0, 32'd0, 32'd0};

	typedef struct packed {
		logic       is_cfg;
		logic       cfg_val;
		logic [1:0] op;
		cmd_t       cmd;
		logic       fixed;
		result_t    want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// [3:0] region_id, [35:4] base_address, [68:36] region_size,
	// [70:69] access_permission, [73:71] memory_type, [74] execute_never,
	// [75] shareable, [79:76] zero
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// [1:0] opcode
	logic [S_TUSER_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// [0] status, [2:1] write_strobe, [5:3] region_number,
	// [37:6] rbar_value, [69:38] rasr_value, [71:70] zero
	logic [M_TDATA_W-1:0] m_tdata;

	// Model state and pending results
	logic [REGIONS-1:0] used_flags = '0;
	logic mpu_present_q = 1'b1;
	result_t pending_results[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int stall_requests = 0;
	int stall_served = 0;
	int hold_left = 0;
	int n_cmds = 0;
	int n_directed = 0;
	int n_results = 0;
	int n_set_ok = 0;
	int n_cfg_writes = 0;
	int n_errors = 0;

	mpu_region_table_encoder #(.REGIONS(REGIONS)) dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always #10 clk = ~clk;

	// Apply one command to the region table and produce its result
	task automatic encode_command(input logic [1:0] op, input cmd_t c, output result_t r);
		int unsigned lg;
		logic cbit;
		logic bbit;
		logic [2:0] ap_enc;
		logic [31:0] rasr;
		r = ERR_RESULT;
		lg = 0;
		for (int k = 5; k <= 32; k++)
			if (c.region_size == (33'd1 << k)) lg = k;
		case (op)
		OP_SET: begin
			if (c.region_id < REGIONS && mpu_present_q && lg != 0 &&
			    ({1'b0, c.base_address} & (c.region_size - 33'd1)) == 33'd0) begin
				if (!used_flags[c.region_id]) begin
					cbit = (c.memory_type == MT_ROM || c.memory_type == MT_RAM ||
					        c.memory_type == MT_PSRAM);
					bbit = (c.memory_type == MT_PSRAM || c.memory_type == MT_NOR);
					case (c.access_permission)
					PERM_RW_PRIV: ap_enc = AP_RW_PRIV;
					PERM_RW_ANY: ap_enc = AP_RW_ANY;
					PERM_RO_PRIV: ap_enc = AP_RO_PRIV;
					default: ap_enc = AP_RO_ANY;
					endcase
					rasr = 32'd1 | (32'(lg - 1) << 1) | (32'(bbit) << 16) | (32'(cbit) << 17)
					     | (32'(c.shareable) << 18) | (32'(ap_enc) << 24)
					     | (32'(c.execute_never) << 28);
					r = '{1'b0, WS_FULL, c.region_id[2:0], c.base_address & RBAR_MASK, rasr};
					used_flags[c.region_id] = 1'b1;
					n_set_ok++;
				end
			end
		end
		OP_DISABLE: begin
			if (c.region_id < REGIONS) begin
				if (used_flags[c.region_id]) begin
					used_flags[c.region_id] = 1'b0;
					r = '{1'b0, (mpu_present_q ? WS_RASR : WS_NONE), c.region_id[2:0],
					      32'd0, 32'd0};
				end
			end
		end
		OP_FIND: begin
			// scan down so the lowest free region wins
			for (int i = REGIONS - 1; i >= 0; i--)
				if (!used_flags[i]) r = '{1'b0, WS_NONE, 3'(i), 32'd0, 32'd0};
		end
		default: r = ERR_RESULT;
		endcase
	endtask

	// Offer one beat, wait for the handshake, queue its result
	task automatic send_command(input logic [1:0] op, input cmd_t c, input logic fixed,
	                            input result_t want);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0, c.shareable, c.execute_never, c.memory_type, c.access_permission,
		            c.region_size, c.base_address, c.region_id};
		do @(posedge clk); while (!s_tready);
		encode_command(op, c, r);
		pending_results.push_back(fixed ? want : r);
		n_cmds++;
		@(negedge clk);
	endtask

	// Drop valid and let every pending result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write mpu_present, then read it back
	task automatic program_mpu_present(input logic val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= MPU_PRESENT_ADDR;
		pwdata <= {31'd0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		mpu_present_q = val;
		n_cfg_writes++;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== {31'd0, val}) begin
			$display("%0t: mpu_present readback mismatch: expected %h, got %h",
			         $time, {31'd0, val}, prdata);
			n_errors++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic dir_row_t cmd_row(input logic [1:0] op, input logic [3:0] id,
	                                     input logic [31:0] base, input logic [32:0] size,
	                                     input logic [1:0] ap, input logic [2:0] mt,
	                                     input logic xn, input logic sh);
		dir_row_t row;
		row = '0;
		row.op = op;
		row.cmd.region_id = id;
		row.cmd.base_address = base;
		row.cmd.region_size = size;
		row.cmd.access_permission = ap;
		row.cmd.memory_type = mt;
		row.cmd.execute_never = xn;
		row.cmd.shareable = sh;
		row.want = ERR_RESULT;
		return row;
	endfunction

	function automatic dir_row_t typed_result(input dir_row_t row, input result_t want);
		row.fixed = 1'b1;
		row.want = want;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(input logic val);
		dir_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.cfg_val = val;
		return row;
	endfunction

	// Pick a random command: mostly well-formed set/disable/find, some noise
	task automatic random_command(output logic [1:0] op, output cmd_t c);
		int unsigned pick;
		int unsigned k;
		logic [32:0] sz;
		pick = $urandom_range(99);
		c.access_permission = 2'($urandom);
		c.memory_type = 3'($urandom);
		c.execute_never = 1'($urandom);
		c.shareable = 1'($urandom);
		c.region_id = ($urandom_range(9) == 0) ? 4'($urandom_range(15, REGIONS))
		                                       : 4'($urandom_range(REGIONS - 1));
		k = $urandom_range(32, 5);
		sz = 33'd1 << k;
		c.region_size = sz;
		c.base_address = $urandom & ~(sz[31:0] - 32'd1);
		if (pick < 40) begin
			op = OP_SET;
		end else if (pick < 70) begin
			op = OP_DISABLE;
			// aim mostly at regions that are in use
			if ($urandom_range(4) != 0)
				for (int t = 0; t < 8 && !(c.region_id < REGIONS && used_flags[c.region_id]); t++)
					c.region_id = 4'($urandom_range(REGIONS - 1));
		end else if (pick < 85) begin
			op = OP_FIND;
		end else begin
			op = 2'($urandom);
			c.region_id = 4'($urandom);
			c.base_address = $urandom;
			c.region_size = {1'($urandom), 32'($urandom)};
		end
	endtask

	task automatic run_random_phase(input int n, input int snd_pct, input int rcv_pct,
	                                input bit pressure);
		logic [1:0] op;
		cmd_t c;
		send_idle_pct = snd_pct;
		recv_idle_pct = rcv_pct;
		for (int i = 0; i < n; i++) begin
			if (pressure && i % 50 == 0) stall_requests++;
			random_command(op, c);
			send_command(op, c, 1'b0, ERR_RESULT);
		end
	endtask

	// Receiver: random stalls, plus long hold-offs on request
	always @(negedge clk) begin
		if (stall_served != stall_requests) begin
			hold_left = PRESSURE_CYCLES;
			stall_served = stall_requests;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
	                                    input logic [31:0] seen);
		if (want !== seen) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, seen);
			n_errors++;
		end
	endfunction

	// Compare each result beat with the oldest pending result
	always @(posedge clk) begin
		result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result beat: expected none, got %h", $time, m_tdata);
				n_errors++;
			end else begin
				exp_r = pending_results.pop_front();
				check_field("status", 32'(exp_r.status), 32'(m_tdata[0]));
				check_field("write_strobe", 32'(exp_r.write_strobe), 32'(m_tdata[2:1]));
				check_field("region_number", 32'(exp_r.region_number), 32'(m_tdata[5:3]));
				check_field("rbar_value", exp_r.rbar_value, m_tdata[37:6]);
				check_field("rasr_value", exp_r.rasr_value, m_tdata[69:38]);
			end
		end
	end

	// Hard stop
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		rows.push_back(typed_result(cmd_row(OP_FIND, 4'd0, 32'd0, 33'd0, 2'd0, MT_ROM, 0, 0),
		                            '{1'b0, WS_NONE, 3'd0, 32'd0, 32'd0}));
		rows.push_back(typed_result(cmd_row(OP_DISABLE, 4'd0, 32'd0, 33'd32, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		// region id out of range
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd8, 32'd0, 33'd32, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd15, 32'd0, 33'd32, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		// sizes below 32, not a power of two, zero, above 4 GiB
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd0, 32'd0, 33'd16, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd0, 32'd0, 33'd48, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd0, 32'd0, 33'd0, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd0, 32'd0, 33'h1_FFFF_FFFF, 2'd3,
		                                    MT_ROM, 1, 1), ERR_RESULT));
		// misaligned base
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd0, 32'h20, 33'd64, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd0, 32'd0, 33'd32, 2'd0, MT_ROM, 0, 0),
		                            '{1'b0, WS_FULL, 3'd0, 32'd0, 32'h0102_0009}));
		// region already in use
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd0, 32'h40, 33'd32, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(cmd_row(OP_SET, 4'd7, 32'd0, 33'h1_0000_0000, 2'd3, MT_PSRAM, 1, 1));
		rows.push_back(cmd_row(OP_SET, 4'd1, 32'hFFFF_FFE0, 33'd32, 2'd1, MT_NOR, 0, 0));
		rows.push_back(cmd_row(OP_SET, 4'd2, 32'h8000_0000, 33'h8000_0000, 2'd2, MT_OTHER, 0, 1));
		rows.push_back(cmd_row(OP_SET, 4'd3, 32'h1000, 33'h1000, 2'd3, 3'd7, 0, 0));
		rows.push_back(cmd_row(OP_SET, 4'd4, 32'h2000_0000, 33'h100, 2'd0, MT_RAM, 1, 0));
		rows.push_back(typed_result(cmd_row(OP_UNKNOWN, 4'd5, 32'd0, 33'd32, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(cmd_row(OP_FIND, 4'd0, 32'd0, 33'd0, 2'd0, MT_ROM, 0, 0));
		rows.push_back(cmd_row(OP_SET, 4'd5, 32'h3F00, 33'h100, 2'd1, MT_RAM, 0, 1));
		rows.push_back(cmd_row(OP_SET, 4'd6, 32'hFFFF_FF00, 33'h100, 2'd2, MT_PSRAM, 1, 0));
		// table full
		rows.push_back(typed_result(cmd_row(OP_FIND, 4'd0, 32'd0, 33'd0, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(typed_result(cmd_row(OP_DISABLE, 4'd15, 32'd0, 33'd0, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(typed_result(cmd_row(OP_DISABLE, 4'd7, 32'd0, 33'd0, 2'd0, MT_ROM, 0, 0),
		                            '{1'b0, WS_RASR, 3'd7, 32'd0, 32'd0}));
		rows.push_back(cmd_row(OP_FIND, 4'd0, 32'd0, 33'd0, 2'd0, MT_ROM, 0, 0));
		// no MPU: set rejected, disable clears without a register write
		rows.push_back(cfg_row(1'b0));
		rows.push_back(typed_result(cmd_row(OP_SET, 4'd7, 32'd0, 33'd32, 2'd0, MT_ROM, 0, 0),
		                            ERR_RESULT));
		rows.push_back(typed_result(cmd_row(OP_DISABLE, 4'd6, 32'd0, 33'd0, 2'd0, MT_ROM, 0, 0),
		                            '{1'b0, WS_NONE, 3'd6, 32'd0, 32'd0}));
		rows.push_back(cfg_row(1'b1));

		// Reset: assert once every process waits on its events
		#1;
		arst_n = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table
		send_idle_pct = 10;
		recv_idle_pct = 30;
		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_drained();
				program_mpu_present(rows[i].cfg_val);
			end else begin
				send_command(rows[i].op, rows[i].cmd, rows[i].fixed, rows[i].want);
				n_directed++;
			end
		end

		// Random phases
		run_random_phase(350, 19, 87, 1'b0);
		wait_drained();
		program_mpu_present(1'b0);
		run_random_phase(180, 87, 19, 1'b0);
		wait_drained();
		program_mpu_present(1'b1);
		run_random_phase(350, 0, 0, 1'b0);
		run_random_phase(170, 0, 0, 1'b1);

		// Drain and report
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("Ran %0d commands (%0d directed), checked %0d results, %0d regions programmed.",
		         n_cmds, n_directed, n_results, n_set_ok);
		$display("mpu_present written %0d times; idle mixes and a full-stall phase exercised.",
		         n_cfg_writes);
		if (n_errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
